// ===== src/mpte_pkg.sv =====
// Package: shared types and constants of the memory patch table engine.
package mpte_pkg;
	localparam int TableDepth = 32;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [3:0] REQ_ADD = 4'd0;
	localparam logic [3:0] REQ_ADD_CODED = 4'd1;
	localparam logic [3:0] REQ_REM_MATCH = 4'd2;
	localparam logic [3:0] REQ_REM_CODED = 4'd3;
	localparam logic [3:0] REQ_REM_INDEX = 4'd4;
	localparam logic [3:0] REQ_CLEAR = 4'd5;
	localparam logic [3:0] REQ_ENABLE = 4'd6;
	localparam logic [3:0] REQ_DISABLE = 4'd7;
	localparam logic [3:0] REQ_RUN = 4'd8;
	localparam logic [3:0] REQ_READ_RESP = 4'd9;

	localparam logic [1:0] KIND_COND = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_WORD = 2'd2;
	localparam logic [1:0] KIND_LONG = 2'd3;

	localparam logic [2:0] RK_OK = 3'd0;
	localparam logic [2:0] RK_ERR = 3'd1;
	localparam logic [2:0] RK_WBYTE = 3'd2;
	localparam logic [2:0] RK_WWORD = 3'd3;
	localparam logic [2:0] RK_WLONG = 3'd4;
	localparam logic [2:0] RK_READ = 3'd5;
	localparam logic [2:0] RK_END = 3'd6;

	localparam logic [3:0] NIB_WORD = 4'h1;
	localparam logic [3:0] NIB_BYTE = 4'h3;
	localparam logic [3:0] NIB_COND = 4'hD;
	localparam logic [31:0] ADDR_MASK = 32'h0FFF_FFFF;

	typedef struct packed {
		logic [3:0] req_type;
		logic [1:0] entry_kind;
		logic [31:0] address;
		logic [31:0] value;
		logic [4:0] entry_index;
		logic [15:0] read_data;
	} req_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [31:0] out_address;
		logic [31:0] out_data;
		logic last;
	} res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] addr;
		logic [31:0] val;
		logic en;
	} entry_t;

	// Controls that every cell sees in the same cycle.
	typedef struct packed {
		logic rotate;
		logic drop;
		logic load;
		logic set_en;
		logic en_val;
		logic [IdxW-1:0] en_idx;
		entry_t load_entry;
	} cell_ctl_t;
endpackage

// ===== src/mpte_cell.sv =====
// One table cell: holds an entry and passes it to its neighbor on rotation or removal.
module mpte_cell (
	input logic clk,
	input mpte_pkg::cell_ctl_t ctl,
	input logic [mpte_pkg::IdxW-1:0] my_idx,
	input logic last_cell,
	input mpte_pkg::entry_t from_next,
	input mpte_pkg::entry_t from_head,
	output mpte_pkg::entry_t entry
);
	mpte_pkg::entry_t entry_q;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			if (last_cell) begin
				entry_q <= ctl.load ? ctl.load_entry : from_head;
			end else begin
				entry_q <= from_next;
			end
		end else if (ctl.drop && my_idx >= ctl.en_idx) begin
			// On a removal every cell from the dropped position onward moves up one place.
			entry_q <= from_next;
		end else if (ctl.set_en && ctl.en_idx == my_idx) begin
			entry_q.en <= ctl.en_val;
		end
	end
endmodule

// ===== src/mpte_chain.sv =====
// Chain of cells forming a rotating table; the head is cell zero.
module mpte_chain (
	input logic clk,
	input mpte_pkg::cell_ctl_t ctl,
	output mpte_pkg::entry_t head
);
	mpte_pkg::entry_t ent [mpte_pkg::TableDepth];
	assign head = ent[0];

	for (genvar i = 0; i < mpte_pkg::TableDepth; i++) begin : g_cell
		mpte_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.my_idx(mpte_pkg::IdxW'(i)),
			.last_cell(i == mpte_pkg::TableDepth - 1),
			.from_next(ent[(i + 1) % mpte_pkg::TableDepth]),
			.from_head(ent[0]),
			.entry(ent[i])
		);
	end
endmodule

// ===== src/memory_patch_table_engine.sv =====
// Top level: request decoder, rotation sequencer and output register.
// The table is a ring of TableDepth cells that rotates one place a cycle, with the head entry
// visible to the sequencer; the rotation holds while a run's write or read request waits on a
// blocked output register. Add, remove, run and read-response requests each rotate the full
// ring once: the accepting idle state, a sweep that turns the ring TableDepth places and a
// closing state that waits on a blocked output register. Clear, enable, disable and error
// requests are answered from idle without a sweep. An append loads the new entry
// into the tail as the ring passes the first free position; a removal finds its entry during
// the sweep and then, in the closing cycle, shifts every later cell up by one place. A run
// emits one request per enabled write entry up to the first enabled condition, which emits
// a read request and waits for the response; otherwise the run ends with a run-ended result.
module memory_patch_table_engine (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mpte_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output mpte_pkg::res_t out_data
);
	localparam int IdxW = mpte_pkg::IdxW;
	localparam int CntW = mpte_pkg::CntW;
	localparam logic [CntW-1:0] DEPTH = CntW'(mpte_pkg::TableDepth);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SWEEP = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_REMOVE,
		OP_RUN
	} op_t;

	state_t state_q;
	op_t op_q;
	mpte_pkg::req_t req_q;
	logic [CntW-1:0] count_q, pos_q, run_pos_q;
	logic awaiting_q, found_q, running_q, cond_ok_q;
	logic [1:0] tkind_q;
	logic [31:0] taddr_q, tval_q;
	mpte_pkg::entry_t head;
	mpte_pkg::cell_ctl_t ctl;
	mpte_pkg::res_t res_q;
	logic res_v_q;

	// Physical rotation rules: the live entries occupy positions 0..count-1 in sweep order.
	logic out_free;
	assign out_free = !res_v_q || out_ready;
	assign out_valid = res_v_q;
	assign out_data = res_q;
	assign in_ready = (state_q == ST_IDLE) && out_free;

	logic [3:0] nib;
	logic dec_ok;
	logic [1:0] dec_kind;
	assign nib = in_data.address[31:28];
	always_comb begin
		dec_ok = 1'b1;
		dec_kind = mpte_pkg::KIND_COND;
		unique case (nib)
			mpte_pkg::NIB_WORD: dec_kind = mpte_pkg::KIND_WORD;
			mpte_pkg::NIB_BYTE: dec_kind = mpte_pkg::KIND_BYTE;
			mpte_pkg::NIB_COND: dec_kind = mpte_pkg::KIND_COND;
			default: dec_ok = 1'b0;
		endcase
	end

	logic live, hit, emit_w;
	logic [2:0] w_kind;
	logic [31:0] w_data;
	assign live = pos_q < count_q;
	assign hit = live && !found_q && head.kind == tkind_q && head.addr == taddr_q
		&& head.val == tval_q;
	// A run emits for enabled live entries at or past the resume point while still running.
	always_comb begin
		emit_w = 1'b0;
		w_kind = mpte_pkg::RK_WLONG;
		w_data = head.val;
		if (op_q == OP_RUN && running_q && live && pos_q >= run_pos_q && head.en) begin
			emit_w = 1'b1;
			case (head.kind)
				mpte_pkg::KIND_COND: begin
					w_kind = mpte_pkg::RK_READ;
					w_data = '0;
				end
				mpte_pkg::KIND_BYTE: begin
					w_kind = mpte_pkg::RK_WBYTE;
					w_data = {24'd0, head.val[7:0]};
				end
				mpte_pkg::KIND_WORD: begin
					w_kind = mpte_pkg::RK_WWORD;
					w_data = {16'd0, head.val[15:0]};
				end
				default: ;
			endcase
		end
	end

	logic sweep_go;
	assign sweep_go = (state_q == ST_SWEEP) && (out_free || !emit_w);

	logic [CntW-1:0] drop_at_q;

	always_comb begin
		ctl = '0;
		ctl.rotate = sweep_go;
		ctl.load_entry.kind = tkind_q;
		ctl.load_entry.addr = taddr_q;
		ctl.load_entry.val = tval_q;
		ctl.load_entry.en = 1'b1;
		// The head at this step is the first free slot, so the tail takes the new entry.
		if (sweep_go && pos_q == count_q && op_q == OP_APPEND) ctl.load = 1'b1;
		ctl.en_idx = drop_at_q[IdxW-1:0];
		ctl.en_val = req_q.req_type == mpte_pkg::REQ_ENABLE;
		ctl.drop = (state_q == ST_FINAL) && out_free && op_q == OP_REMOVE && found_q;
	end

	mpte_pkg::cell_ctl_t cctl;
	always_comb begin
		cctl = ctl;
		cctl.set_en = 1'b0;
		if (state_q == ST_IDLE && in_valid && in_ready
				&& CntW'(in_data.entry_index) < count_q
				&& (in_data.req_type == mpte_pkg::REQ_ENABLE
				|| in_data.req_type == mpte_pkg::REQ_DISABLE)) begin
			cctl.set_en = 1'b1;
			cctl.en_idx = in_data.entry_index[IdxW-1:0];
			cctl.en_val = in_data.req_type == mpte_pkg::REQ_ENABLE;
		end
	end

	mpte_chain u_chain (.clk(clk), .ctl(cctl), .head(head));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			awaiting_q <= 1'b0;
			run_pos_q <= '0;
			res_v_q <= 1'b0;
			pos_q <= '0;
			found_q <= 1'b0;
			running_q <= 1'b0;
			drop_at_q <= '0;
			cond_ok_q <= 1'b0;
			op_q <= OP_APPEND;
		end else begin
			if (out_ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						pos_q <= '0;
						found_q <= 1'b0;
						if (in_data.req_type <= mpte_pkg::REQ_RUN) begin
							awaiting_q <= 1'b0;
							run_pos_q <= '0;
						end
						res_q <= '{result_kind: mpte_pkg::RK_ERR, out_address: '0,
							out_data: '0, last: 1'b1};
						res_v_q <= 1'b1;
						case (in_data.req_type)
							mpte_pkg::REQ_ADD, mpte_pkg::REQ_ADD_CODED: begin
								tkind_q <= in_data.req_type == mpte_pkg::REQ_ADD
									? in_data.entry_kind : dec_kind;
								taddr_q <= in_data.req_type == mpte_pkg::REQ_ADD
									? in_data.address : in_data.address & mpte_pkg::ADDR_MASK;
								tval_q <= in_data.req_type == mpte_pkg::REQ_ADD
									? in_data.value : {16'd0, in_data.value[15:0]};
								if (count_q < DEPTH && (in_data.req_type == mpte_pkg::REQ_ADD
										|| dec_ok)) begin
									res_v_q <= 1'b0;
									op_q <= OP_APPEND;
									state_q <= ST_SWEEP;
								end
							end
							mpte_pkg::REQ_REM_MATCH, mpte_pkg::REQ_REM_CODED,
							mpte_pkg::REQ_REM_INDEX: begin
								tkind_q <= in_data.req_type == mpte_pkg::REQ_REM_CODED
									? dec_kind : in_data.entry_kind;
								taddr_q <= in_data.req_type == mpte_pkg::REQ_REM_CODED
									? in_data.address & mpte_pkg::ADDR_MASK : in_data.address;
								tval_q <= in_data.req_type == mpte_pkg::REQ_REM_CODED
									? {16'd0, in_data.value[15:0]} : in_data.value;
								if ((in_data.req_type != mpte_pkg::REQ_REM_CODED || dec_ok)
										&& (in_data.req_type != mpte_pkg::REQ_REM_INDEX
										|| CntW'(in_data.entry_index) < count_q)) begin
									res_v_q <= 1'b0;
									op_q <= OP_REMOVE;
									state_q <= ST_SWEEP;
								end
							end
							mpte_pkg::REQ_CLEAR: begin
								count_q <= '0;
								res_q.result_kind <= mpte_pkg::RK_OK;
							end
							mpte_pkg::REQ_ENABLE, mpte_pkg::REQ_DISABLE: begin
								if (CntW'(in_data.entry_index) < count_q)
									res_q.result_kind <= mpte_pkg::RK_OK;
							end
							mpte_pkg::REQ_RUN: begin
								res_v_q <= 1'b0;
								op_q <= OP_RUN;
								running_q <= 1'b1;
								cond_ok_q <= 1'b1;
								state_q <= ST_SWEEP;
							end
							mpte_pkg::REQ_READ_RESP: begin
								if (awaiting_q && run_pos_q < count_q) begin
									res_v_q <= 1'b0;
									op_q <= OP_RUN;
									running_q <= 1'b0;
									cond_ok_q <= 1'b0;
									tval_q <= {16'd0, in_data.read_data};
									state_q <= ST_SWEEP;
								end else begin
									awaiting_q <= 1'b0;
									run_pos_q <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (sweep_go) begin
						pos_q <= pos_q + CntW'(1);
						// Read response: compare at the waiting entry and, on a match, resume after it.
						if (op_q == OP_RUN && !running_q && pos_q == run_pos_q && live)
							if (head.val == tval_q) begin
								running_q <= 1'b1;
								cond_ok_q <= 1'b1;
								run_pos_q <= run_pos_q + CntW'(1);
							end
						if (op_q == OP_REMOVE) begin
							if ((req_q.req_type == mpte_pkg::REQ_REM_INDEX
									&& pos_q == CntW'(req_q.entry_index)) || (hit
									&& req_q.req_type != mpte_pkg::REQ_REM_INDEX)) begin
								found_q <= 1'b1;
								drop_at_q <= pos_q;
							end
						end
						if (emit_w) begin
							res_q <= '{result_kind: w_kind, out_address: head.addr,
								out_data: w_data, last: head.kind == mpte_pkg::KIND_COND};
							res_v_q <= 1'b1;
							if (head.kind == mpte_pkg::KIND_COND) begin
								running_q <= 1'b0;
								awaiting_q <= 1'b1;
								run_pos_q <= pos_q;
							end
						end
						if (pos_q == DEPTH - CntW'(1)) state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						res_q <= '{result_kind: mpte_pkg::RK_OK, out_address: '0,
							out_data: '0, last: 1'b1};
						state_q <= ST_IDLE;
						res_v_q <= 1'b1;
						case (op_q)
							OP_APPEND: count_q <= count_q + CntW'(1);
							OP_REMOVE: begin
								if (!found_q) begin
									res_q.result_kind <= mpte_pkg::RK_ERR;
								end else begin
									// The cells close the gap in this same cycle.
									count_q <= count_q - CntW'(1);
								end
							end
							default: begin
								if (running_q || !cond_ok_q) begin
									res_q.result_kind <= mpte_pkg::RK_END;
									awaiting_q <= 1'b0;
									run_pos_q <= '0;
									running_q <= 1'b0;
								end else begin
									res_v_q <= 1'b0;
								end
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH) else $error("count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
endmodule
